// ===== rtl/olr_pkg.sv =====
package olr_pkg;

  localparam int unsigned CoordW   = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DefMaxDim = 64;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [DimW-1:0]   dim_t;
  typedef logic [CharW-1:0]  pix_t;

  typedef enum logic [1:0] {
    STAT_CELL     = 2'd0,
    STAT_OUTSIDE  = 2'd1,
    STAT_NOT_DIAG = 2'd2
  } status_e;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN
  } state_e;

  // one step of the walker: next point plus end flag
  typedef struct packed {
    coord_t next_row;
    coord_t next_col;
    logic   at_end;
  } step_t;

endpackage

// ===== rtl/olr_check.sv =====
module olr_check (
  input  logic          opcode_i,
  input  olr_pkg::coord_t start_row_i,
  input  olr_pkg::coord_t start_col_i,
  input  olr_pkg::coord_t end_row_i,
  input  olr_pkg::coord_t end_col_i,
  input  olr_pkg::dim_t   rows_i,
  input  olr_pkg::dim_t   cols_i,
  output olr_pkg::status_e status_o
);
  import olr_pkg::*;

  logic   start_in, end_in;
  coord_t dr, dc;

  function automatic logic is_inside(coord_t r, coord_t c, dim_t nr, dim_t nc);
    logic ok;
    ok = (r != '0) && ((DimW'(r) + 7'd1) < nr) &&
         (c != '0) && ((DimW'(c) + 7'd1) < nc);
    return ok;
  endfunction

  assign start_in = is_inside(start_row_i, start_col_i, rows_i, cols_i);
  assign end_in   = is_inside(end_row_i, end_col_i, rows_i, cols_i);
  assign dr = (start_row_i > end_row_i) ? start_row_i - end_row_i : end_row_i - start_row_i;
  assign dc = (start_col_i > end_col_i) ? start_col_i - end_col_i : end_col_i - start_col_i;

  always_comb begin
    if (!start_in || (!opcode_i && !end_in)) begin
      status_o = STAT_OUTSIDE;
    end else if (!opcode_i && dr != '0 && dc != '0 && dr != dc) begin
      status_o = STAT_NOT_DIAG;
    end else begin
      status_o = STAT_CELL;
    end
  end

endmodule

// ===== rtl/olr_step.sv =====
module olr_step (
  input  olr_pkg::coord_t cur_row_i,
  input  olr_pkg::coord_t cur_col_i,
  input  olr_pkg::coord_t tgt_row_i,
  input  olr_pkg::coord_t tgt_col_i,
  output olr_pkg::step_t  step_o
);
  import olr_pkg::*;

  always_comb begin
    step_o.at_end = (cur_row_i == tgt_row_i) && (cur_col_i == tgt_col_i);
    if (cur_row_i < tgt_row_i) begin
      step_o.next_row = cur_row_i + 6'd1;
    end else if (cur_row_i > tgt_row_i) begin
      step_o.next_row = cur_row_i - 6'd1;
    end else begin
      step_o.next_row = cur_row_i;
    end
    if (cur_col_i < tgt_col_i) begin
      step_o.next_col = cur_col_i + 6'd1;
    end else if (cur_col_i > tgt_col_i) begin
      step_o.next_col = cur_col_i - 6'd1;
    end else begin
      step_o.next_col = cur_col_i;
    end
  end

endmodule

// ===== rtl/octilinear_line_rasterizer_unit.sv =====
// Flow: a command is captured on input transfer, checked in ST_CHECK, then walked in ST_RUN.
// A command yields N cells, N = cells on the line (1..62), or a single reject item; the single
//   step unit walks one cell a cycle while the output is not stalled.
// Output stalls hold the walker; a new command is taken only after the last item is loaded.
// Reset (rst_ni low, async): sequencer idle, output empty, row/column counts set to 64.
module octilinear_line_rasterizer_unit #(
  parameter int unsigned MAX_DIM = olr_pkg::DefMaxDim
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_row[5:0], start_col[11:6], end_row[17:12], end_col[23:18], pixel_char[31:24]
  input  logic [31:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_row[5:0], cell_col[11:6], cell_char[19:12], zero[23:20]
  output logic [23:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import olr_pkg::*;

  state_e  state_q, state_d;
  dim_t    rows_q, cols_q, rows_eff, cols_eff;
  logic    op_q;
  coord_t  sr_q, sc_q, er_q, ec_q;
  pix_t    ch_q;
  coord_t  cur_r_q, cur_r_d, cur_c_q, cur_c_d, tgt_r_q, tgt_r_d, tgt_c_q, tgt_c_d;
  status_e chk_status;
  step_t   step;

  logic    out_free, load_out;
  logic    ov_q;
  coord_t  or_q, oc_q, or_d, oc_d;
  pix_t    och_q, och_d;
  status_e ost_q, ost_d;
  logic    olast_q, olast_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd64;
      cols_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROW_COUNT: rows_q <= cfg_data_i;
        REG_COL_COUNT: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_eff = (rows_q > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : rows_q;
  assign cols_eff = (cols_q > DimW'(MAX_DIM)) ? DimW'(MAX_DIM) : cols_q;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tuser;
      sr_q <= s_axis_tdata[5:0];
      sc_q <= s_axis_tdata[11:6];
      er_q <= s_axis_tdata[17:12];
      ec_q <= s_axis_tdata[23:18];
      ch_q <= s_axis_tdata[31:24];
    end
  end

  olr_check u_check (
    .opcode_i    (op_q),
    .start_row_i (sr_q),
    .start_col_i (sc_q),
    .end_row_i   (er_q),
    .end_col_i   (ec_q),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .status_o    (chk_status)
  );

  olr_step u_step (
    .cur_row_i (cur_r_q),
    .cur_col_i (cur_c_q),
    .tgt_row_i (tgt_r_q),
    .tgt_col_i (tgt_c_q),
    .step_o    (step)
  );

  assign out_free = !ov_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_CHECK;
      ST_CHECK: begin
        if (chk_status != STAT_CELL) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN:   if (out_free && step.at_end) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and output control
  always_comb begin
    cur_r_d  = cur_r_q;
    cur_c_d  = cur_c_q;
    tgt_r_d  = tgt_r_q;
    tgt_c_d  = tgt_c_q;
    load_out = 1'b0;
    or_d     = '0;
    oc_d     = '0;
    och_d    = '0;
    ost_d    = STAT_CELL;
    olast_d  = 1'b1;
    unique case (state_q)
      ST_CHECK: begin
        cur_r_d = sr_q;
        cur_c_d = sc_q;
        // upward run ends at row 1 of the start column
        tgt_r_d = op_q ? 6'd1 : er_q;
        tgt_c_d = op_q ? sc_q : ec_q;
        if (chk_status != STAT_CELL && out_free) begin
          load_out = 1'b1;
          ost_d    = chk_status;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          load_out = 1'b1;
          or_d     = cur_r_q;
          oc_d     = cur_c_q;
          och_d    = ch_q;
          olast_d  = step.at_end;
          cur_r_d  = step.next_row;
          cur_c_d  = step.next_col;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    tgt_r_q <= tgt_r_d;
    tgt_c_q <= tgt_c_d;
    if (load_out) begin
      or_q    <= or_d;
      oc_q    <= oc_d;
      och_q   <= och_d;
      ost_q   <= ost_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, och_q, oc_q, or_q};
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;

`ifndef NO_ASSERTIONS
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_CHECK)
    else $error("accepted command did not enter check");

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_CELL |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("rejection item malformed");

  a_cell_in_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_CELL |->
      m_axis_tdata[5:0] != '0 && m_axis_tdata[11:6] != '0)
    else $error("cell written on border row or column");

  a_run_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && out_free && step.at_end |=> state_q == ST_IDLE && m_axis_tlast)
    else $error("run did not close with last item");
`endif

endmodule

// ===== dv/octilinear_line_rasterizer_unit_test.sv =====
module octilinear_line_rasterizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olr_pkg::*;

  localparam int CycleLimit = 4_000_000;
  localparam int NumPhases  = 7;

  typedef enum logic {
    OP_LINE   = 1'b0,
    OP_UPWARD = 1'b1
  } opcode_e;

  typedef struct {
    opcode_e op;
    coord_t  start_row;
    coord_t  start_col;
    coord_t  end_row;
    coord_t  end_col;
    pix_t    pix;
  } line_cmd_t;

  typedef struct {
    coord_t  row;
    coord_t  col;
    pix_t    ch;
    status_e st;
    logic    last;
  } cell_t;

  class raster_scoreboard;
    cell_t cells_due[$];
    int    rows = 64;
    int    cols = 64;
    int    errors;
    int    commands;
    int    cells_seen;
    int    outside_seen;
    int    diag_seen;

    function int clip(int v);
      return (v > DefMaxDim) ? DefMaxDim : v;
    endfunction

    function bit interior(int r, int c);
      return r >= 1 && r + 1 < clip(rows) && c >= 1 && c + 1 < clip(cols);
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    function void due(int r, int c, pix_t ch, status_e st, bit last);
      cell_t e;
      e.row  = coord_t'(r);
      e.col  = coord_t'(c);
      e.ch   = ch;
      e.st   = st;
      e.last = last;
      cells_due.push_back(e);
    endfunction

    // walk the line exactly as the hardware should, one cell per step
    function void note_command(line_cmd_t cmd);
      int r, c, r2, c2, dr, dc, steps, i;
      commands++;
      r  = cmd.start_row;
      c  = cmd.start_col;
      r2 = cmd.end_row;
      c2 = cmd.end_col;
      if (cmd.op == OP_UPWARD) begin
        if (!interior(r, c)) begin
          due(0, 0, '0, STAT_OUTSIDE, 1'b1);
        end else begin
          for (; r >= 1; r--) due(r, c, cmd.pix, STAT_CELL, r == 1);
        end
        return;
      end
      if (!interior(r, c) || !interior(r2, c2)) begin
        due(0, 0, '0, STAT_OUTSIDE, 1'b1);
        return;
      end
      dr = (r > r2) ? r - r2 : r2 - r;
      dc = (c > c2) ? c - c2 : c2 - c;
      if (dr != 0 && dc != 0 && dr != dc) begin
        due(0, 0, '0, STAT_NOT_DIAG, 1'b1);
        return;
      end
      steps = (dr > dc) ? dr : dc;
      for (i = 0; i <= steps; i++) begin
        due(r, c, cmd.pix, STAT_CELL, i == steps);
        if (r < r2) r++; else if (r > r2) r--;
        if (c < c2) c++; else if (c > c2) c--;
      end
    endfunction

    task report(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_cell(logic [23:0] data, logic [1:0] user, logic last);
      cell_t e;
      if (cells_due.size() == 0) begin
        report($sformatf("unexpected transfer: row %0d col %0d status %0d",
                         data[5:0], data[11:6], user));
        return;
      end
      e = cells_due.pop_front();
      compare("cell_row", data[5:0], e.row);
      compare("cell_col", data[11:6], e.col);
      compare("cell_char", data[19:12], e.ch);
      compare("tdata pad", data[23:20], 0);
      compare("status", user, e.st);
      compare("tlast", last, e.last);
      case (e.st)
        STAT_CELL:     cells_seen++;
        STAT_OUTSIDE:  outside_seen++;
        STAT_NOT_DIAG: diag_seen++;
        default: ;
      endcase
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [6:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  raster_scoreboard sb;
  bit tx_calm;
  bit rx_calm;
  int rx_hold;
  int cycle_count = 0;

  int phase_rows[NumPhases]  = '{64, 3, 64, 127, 0, 0, 64};
  int phase_cols[NumPhases]  = '{64, 64, 3, 65, 2, 0, 64};
  int phase_items[NumPhases] = '{30, 25, 25, 30, 12, 40, 30};

  octilinear_line_rasterizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // mostly no gap, some short ones, a few long
  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 65) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic line_cmd_t make_cmd(opcode_e op, int r1, int c1, int r2, int c2,
                                         int pix);
    line_cmd_t c;
    c.op        = op;
    c.start_row = coord_t'(r1);
    c.start_col = coord_t'(c1);
    c.end_row   = coord_t'(r2);
    c.end_col   = coord_t'(c2);
    c.pix       = pix_t'(pix);
    return c;
  endfunction

  // nr/nc: effective grid size; mostly well-formed lines, the rest noise
  function automatic line_cmd_t random_command(int nr, int nc);
    line_cmd_t c;
    int kind, r, col, dr, dc, lim;
    kind = $urandom_range(0, 99);
    c = make_cmd(OP_LINE, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
    if (nr < 3 || nc < 3 || kind < 12) begin
      c.op = opcode_e'($urandom_range(0, 1));
      return c;
    end
    r   = $urandom_range(1, nr - 2);
    col = $urandom_range(1, nc - 2);
    c.start_row = coord_t'(r);
    c.start_col = coord_t'(col);
    if (kind < 27) begin
      c.op = OP_UPWARD;
    end else if (kind < 37) begin
      c.end_row = coord_t'($urandom_range(1, nr - 2));
      c.end_col = coord_t'($urandom_range(1, nc - 2));
    end else begin
      dr  = $urandom_range(0, 2) - 1;
      dc  = $urandom_range(0, 2) - 1;
      lim = 62;
      if (dr > 0 && nr - 2 - r < lim) lim = nr - 2 - r;
      if (dr < 0 && r - 1 < lim) lim = r - 1;
      if (dc > 0 && nc - 2 - col < lim) lim = nc - 2 - col;
      if (dc < 0 && col - 1 < lim) lim = col - 1;
      if (dr == 0 && dc == 0) lim = 0;
      lim = $urandom_range(0, lim);
      c.end_row = coord_t'(r + dr * lim);
      c.end_col = coord_t'(col + dc * lim);
    end
    return c;
  endfunction

  task automatic send_command(line_cmd_t c);
    int g;
    g = tx_calm ? 0 : idle_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= {c.pix, c.end_col, c.end_row, c.start_col, c.start_row};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_grid(int rows, int cols);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ROW_COUNT;
    cfg_data_i <= dim_t'(rows);
    @(posedge clk_i);
    sb.rows = rows;
    cfg_idx_i  <= REG_COL_COUNT;
    cfg_data_i <= dim_t'(cols);
    @(posedge clk_i);
    sb.cols = cols;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (rx_hold > 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin : rx_pace
      int n;
      n = rx_calm ? 0 : idle_len();
      rx_hold       <= n;
      m_axis_tready <= (n == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_cell(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    line_cmd_t directed[$];
    int p, i, nr, nc;
    sb            = new();
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ROW_COUNT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LINE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-size grid after reset: corners, all eight directions, rejects
    directed.push_back(make_cmd(OP_LINE, 1, 1, 1, 62, 8'h00));
    directed.push_back(make_cmd(OP_LINE, 62, 62, 62, 1, 8'hFF));
    directed.push_back(make_cmd(OP_LINE, 1, 1, 62, 1, 8'h2A));
    directed.push_back(make_cmd(OP_LINE, 62, 62, 1, 62, 8'h55));
    directed.push_back(make_cmd(OP_LINE, 1, 1, 62, 62, 8'hAA));
    directed.push_back(make_cmd(OP_LINE, 62, 62, 1, 1, 8'h01));
    directed.push_back(make_cmd(OP_LINE, 62, 1, 1, 62, 8'h80));
    directed.push_back(make_cmd(OP_LINE, 1, 62, 62, 1, 8'h7F));
    directed.push_back(make_cmd(OP_LINE, 31, 17, 31, 17, 8'h23));
    directed.push_back(make_cmd(OP_LINE, 5, 5, 9, 20, 8'h11));
    directed.push_back(make_cmd(OP_LINE, 0, 5, 5, 5, 8'h12));
    directed.push_back(make_cmd(OP_LINE, 5, 5, 5, 63, 8'h13));
    // outside and off-diagonal together: outside wins
    directed.push_back(make_cmd(OP_LINE, 2, 3, 63, 40, 8'h14));
    directed.push_back(make_cmd(OP_LINE, 7, 0, 7, 9, 8'h15));
    directed.push_back(make_cmd(OP_UPWARD, 62, 62, 63, 63, 8'hA5));
    directed.push_back(make_cmd(OP_UPWARD, 1, 1, 0, 0, 8'h5A));
    directed.push_back(make_cmd(OP_UPWARD, 63, 10, 4, 4, 8'h16));
    directed.push_back(make_cmd(OP_UPWARD, 10, 0, 4, 4, 8'h17));
    directed.push_back(make_cmd(OP_UPWARD, 0, 10, 4, 4, 8'h18));
    foreach (directed[k]) send_command(directed[k]);

    for (p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain();
        if (p == 5) set_grid($urandom_range(3, 64), $urandom_range(3, 64));
        else set_grid(phase_rows[p], phase_cols[p]);
      end
      rx_calm = (p == 2) || (p == 5);
      nr = sb.clip(sb.rows);
      nc = sb.clip(sb.cols);
      for (i = 0; i < phase_items[p]; i++) begin
        tx_calm = (p == 2) || (p == 5 && i >= 20);
        // hold off until the block has fully emptied
        if (p == 6 && i == 15) drain();
        send_command(random_command(nr, nc));
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands over %0d grid settings, including oversize and empty grids.",
             sb.commands, NumPhases);
    $display("Saw %0d cell writes, %0d outside rejects, %0d not-diagonal rejects.",
             sb.cells_seen, sb.outside_seen, sb.diag_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/olr_pkg.sv
rtl/olr_check.sv
rtl/olr_step.sv
rtl/octilinear_line_rasterizer_unit.sv
dv/octilinear_line_rasterizer_unit_test.sv
